### rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Shared types, register indexes, sine coefficients and fixed-point helpers.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SLICES = 2'd1;
  localparam logic [1:0] REG_STACKS = 2'd2;

  localparam int NUM_W = 24;
  localparam int DIV_LANES = 3;

  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598670;
  localparam logic [31:0] SIN_C5 = 32'd85569306;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C9 = 32'd172272;

  typedef struct packed {
    logic [7:0]       rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
  } uvs_div_t;

  typedef struct packed {
    logic [31:0] p;
    logic [28:0] s;
    logic [14:0] t;
    logic        neg;
  } uvs_horner_t;

  typedef struct packed {
    logic        oor;
    logic        quad_valid;
    logic [15:0] quad_base;
    logic [15:0] quad_below;
  } uvs_side_t;

  typedef struct packed {
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } uvs_tex_t;

  // Product of two signed values rescaled by 2^-14, rounded half away from zero.
  function automatic logic signed [18:0] mul_q14(input logic signed [16:0] a,
                                                 input logic signed [16:0] b);
    logic [16:0] ma;
    logic [16:0] mb;
    logic [33:0] prod;
    logic [18:0] mag;
    ma   = a[16] ? 17'(-a) : 17'(a);
    mb   = b[16] ? 17'(-b) : 17'(b);
    prod = 34'(ma) * 34'(mb) + 34'd8192;
    mag  = 19'(prod >> 14);
    return (a[16] != b[16]) ? -signed'(mag) : signed'(mag);
  endfunction

endpackage

### rtl/uvs_div_cell.sv
// ----------------------------------------------------------------------------
// Division cell
// One restoring long-division step: takes one numerator bit, yields one
// quotient bit and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module uvs_div_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [7:0]      divisor_i,
  input  uvs_pkg::uvs_div_t cell_i,
  output uvs_pkg::uvs_div_t cell_o
);

  logic [8:0]        trial;
  logic              ge;
  uvs_pkg::uvs_div_t cell_d;
  uvs_pkg::uvs_div_t cell_q;

  always_comb begin
    trial = {cell_i.rem, cell_i.num[uvs_pkg::NUM_W-1]};
    ge    = trial >= {1'b0, divisor_i};
    cell_d.rem = ge ? 8'(trial - {1'b0, divisor_i}) : trial[7:0];
    cell_d.num = {cell_i.num[uvs_pkg::NUM_W-2:0], 1'b0};
    cell_d.quo = {cell_i.quo[uvs_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### rtl/uvs_horner_cell.sv
// ----------------------------------------------------------------------------
// Horner cell
// One step of the sine polynomial: p <= COEF - (p * t^2 >> 28).
// ----------------------------------------------------------------------------
module uvs_horner_cell #(
  parameter logic [31:0] COEF = 32'd0
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  uvs_pkg::uvs_horner_t  cell_i,
  output uvs_pkg::uvs_horner_t  cell_o
);

  logic [60:0]          prod;
  uvs_pkg::uvs_horner_t cell_d;
  uvs_pkg::uvs_horner_t cell_q;

  always_comb begin
    prod     = 61'(cell_i.p) * 61'(cell_i.s);
    cell_d   = cell_i;
    cell_d.p = COEF - prod[59:28];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### rtl/uvs_sine.sv
// ----------------------------------------------------------------------------
// Pipelined sine
// Sine of a 16-bit phase in Q14 through a quarter-wave fold, a chain of
// Horner cells and a rounding stage.
// ----------------------------------------------------------------------------
module uvs_sine (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [15:0]        phase_i,
  output logic signed [15:0] sin_o
);

  localparam logic [31:0] COEFS [4] = '{uvs_pkg::SIN_C7, uvs_pkg::SIN_C5,
                                       uvs_pkg::SIN_C3, uvs_pkg::SIN_C1};

  logic [14:0]          t;
  uvs_pkg::uvs_horner_t fold_d;
  uvs_pkg::uvs_horner_t chain [5];
  logic [46:0]          prod;
  logic [16:0]          mag_d;
  logic [16:0]          mag_q;
  logic                 neg_q;
  logic [14:0]          clamped;
  logic signed [15:0]   sin_d;
  logic signed [15:0]   sin_q;

  always_comb begin
    t = phase_i[14] ? 15'(15'd16384 - {1'b0, phase_i[13:0]}) : {1'b0, phase_i[13:0]};
    fold_d.p   = uvs_pkg::SIN_C9;
    fold_d.s   = 29'(30'(t) * 30'(t));
    fold_d.t   = t;
    fold_d.neg = phase_i[15];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chain[0] <= fold_d;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_horner
    uvs_horner_cell #(.COEF(COEFS[k])) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  always_comb begin
    prod  = 47'(chain[4].p) * 47'(chain[4].t) + 47'(64'd1 << 29);
    mag_d = prod[46:30];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= chain[4].neg;
    end
  end

  always_comb begin
    clamped = (mag_q > 17'd16384) ? 15'd16384 : mag_q[14:0];
    sin_d   = neg_q ? -signed'({1'b0, clamped}) : signed'({1'b0, clamped});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
    end
  end

  assign sin_o = sin_q;

endmodule

### rtl/uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Position, normal, texture coordinates and quad indices of one grid point
// of a latitude-longitude sphere.
// ----------------------------------------------------------------------------
// A request on the slave stream carries a stack and a slice index; each one
// yields exactly one result on the master stream, in order. The configuration
// channel writes radius, slice count and stack count and is always ready; the
// user must write it only while no request is in flight, and the block itself
// does not enforce this. The data path is one enabled pipeline of 34 stages:
// an input register, three lanes of 24 long-division cells computing the
// phase and texture ratios, seven sine stages, a normal stage and a position
// stage. Throughput is one request per cycle while the spare entry of the
// output buffer is empty.
// A two-entry output buffer follows the pipeline. The pipeline and the slave
// ready advance whenever the spare entry is empty, so a request is taken
// while a result waits to be taken; a stalled cycle in which a new result
// arrives fills the spare entry, and the pipeline then stops with everything
// held in place until the waiting result is taken.
// Reset clears all valid bits and loads the configuration reset values:
// radius 1.0, 16 slices and 16 stacks.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator #(
  parameter int MAX_DIVISIONS = 255
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,  // stack_index, slice_index
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                      // tex_u, tex_v, quad_base, quad_below, zero pad
  output logic [1:0]   m_axis_tuser,  // quad_valid, out_of_range
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  localparam int DEPTH = 34;
  localparam int LAST = DEPTH - 1;
  localparam int DIV_END = 24;

  typedef struct packed {
    logic [167:0] data;
    logic [1:0]   user;
  } res_t;

  logic [15:0] radius_q;
  logic [7:0]  slices_cfg_q;
  logic [7:0]  stacks_cfg_q;
  logic [7:0]  slices;
  logic [7:0]  stacks;

  logic             en;
  logic [DEPTH-1:0] valid_q;
  logic [7:0]       stack_q;
  logic [7:0]       slice_q;

  uvs_pkg::uvs_side_t side_d;
  uvs_pkg::uvs_side_t side_q [1:LAST-1];
  uvs_pkg::uvs_tex_t  tex_d;
  uvs_pkg::uvs_tex_t  tex_q [DIV_END+1:LAST-1];
  uvs_pkg::uvs_div_t  div_s [uvs_pkg::DIV_LANES][DIV_END+1];
  logic [7:0]         divisor [uvs_pkg::DIV_LANES];

  logic [16:0] base_full;
  logic [15:0] theta;
  logic [15:0] phi;

  logic signed [15:0] sin_t;
  logic signed [15:0] cos_t;
  logic signed [15:0] sin_p;
  logic signed [15:0] cos_p;

  logic signed [15:0] nx_q;
  logic signed [15:0] ny_q;
  logic signed [15:0] nz_q;

  res_t res_d;
  res_t res_q;
  res_t out_q;
  res_t spare_q;
  logic out_valid_q;
  logic spare_valid_q;
  logic out_fire;
  logic push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= 16'd256;
      slices_cfg_q <= 8'd16;
      stacks_cfg_q <= 8'd16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        uvs_pkg::REG_RADIUS: radius_q     <= cfg_data_i;
        uvs_pkg::REG_SLICES: slices_cfg_q <= cfg_data_i[7:0];
        uvs_pkg::REG_STACKS: stacks_cfg_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (slices_cfg_q < 8'd3) begin
      slices = 8'd3;
    end else if (32'(slices_cfg_q) > MAX_DIVISIONS) begin
      slices = 8'(MAX_DIVISIONS);
    end else begin
      slices = slices_cfg_q;
    end
    if (stacks_cfg_q < 8'd2) begin
      stacks = 8'd2;
    end else if (32'(stacks_cfg_q) > MAX_DIVISIONS) begin
      stacks = 8'(MAX_DIVISIONS);
    end else begin
      stacks = stacks_cfg_q;
    end
  end

  assign en            = !spare_valid_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[DEPTH-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stack_q <= s_axis_tdata[7:0];
      slice_q <= s_axis_tdata[15:8];
    end
  end

  always_comb begin
    base_full          = 17'(stack_q) * 17'({1'b0, slices} + 9'd1) + 17'(slice_q);
    side_d.oor         = (stack_q > stacks) || (slice_q > slices);
    side_d.quad_valid  = (stack_q < stacks) && (slice_q < slices);
    side_d.quad_base   = side_d.oor ? 16'd0 : base_full[15:0];
    side_d.quad_below  = side_d.quad_valid ?
                         16'(base_full[15:0] + 16'(slices) + 16'd1) : 16'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[1] <= side_d;
      for (int k = 2; k <= LAST - 1; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign divisor[0] = slices;
  assign divisor[1] = stacks;
  assign divisor[2] = stacks;

  assign div_s[0][0] = '{rem: 8'd0, quo: '0,
                         num: {slice_q, 9'd0, slices[7:1]}};
  assign div_s[1][0] = '{rem: 8'd0, quo: '0,
                         num: {stack_q, 9'd0, stacks[7:1]}};
  assign div_s[2][0] = '{rem: 8'd0, quo: '0,
                         num: {1'b0, stack_q, 8'd0, stacks[7:1]}};

  for (genvar l = 0; l < uvs_pkg::DIV_LANES; l++) begin : g_lane
    for (genvar c = 0; c < DIV_END; c++) begin : g_cell
      uvs_div_cell u_cell (
        .clk_i     (clk_i),
        .en_i      (en),
        .divisor_i (divisor[l]),
        .cell_i    (div_s[l][c]),
        .cell_o    (div_s[l][c+1])
      );
    end
  end

  assign theta       = div_s[0][DIV_END].quo[15:0];
  assign phi         = div_s[2][DIV_END].quo[15:0];
  assign tex_d.tex_u = div_s[0][DIV_END].quo[16:0];
  assign tex_d.tex_v = div_s[1][DIV_END].quo[16:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tex_q[DIV_END+1] <= tex_d;
      for (int k = DIV_END + 2; k <= LAST - 1; k++) begin
        tex_q[k] <= tex_q[k-1];
      end
    end
  end

  uvs_sine u_sin_theta (.clk_i(clk_i), .en_i(en), .phase_i(theta), .sin_o(sin_t));
  uvs_sine u_cos_theta (.clk_i(clk_i), .en_i(en), .phase_i(16'(theta + 16'd16384)),
                        .sin_o(cos_t));
  uvs_sine u_sin_phi (.clk_i(clk_i), .en_i(en), .phase_i(phi), .sin_o(sin_p));
  uvs_sine u_cos_phi (.clk_i(clk_i), .en_i(en), .phase_i(16'(phi + 16'd16384)),
                      .sin_o(cos_p));

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= 16'(uvs_pkg::mul_q14(17'(sin_p), 17'(cos_t)));
      ny_q <= cos_p;
      nz_q <= 16'(uvs_pkg::mul_q14(17'(sin_p), 17'(sin_t)));
    end
  end

  always_comb begin
    res_d.data          = '0;
    res_d.data[16:0]    = 17'(uvs_pkg::mul_q14(signed'({1'b0, radius_q}), 17'(nx_q)));
    res_d.data[33:17]   = 17'(uvs_pkg::mul_q14(signed'({1'b0, radius_q}), 17'(ny_q)));
    res_d.data[50:34]   = 17'(uvs_pkg::mul_q14(signed'({1'b0, radius_q}), 17'(nz_q)));
    res_d.data[66:51]   = nx_q;
    res_d.data[82:67]   = ny_q;
    res_d.data[98:83]   = nz_q;
    res_d.data[115:99]  = tex_q[LAST-1].tex_u;
    res_d.data[132:116] = tex_q[LAST-1].tex_v;
    if (side_q[LAST-1].oor) begin
      res_d.data = '0;
    end
    res_d.data[148:133] = side_q[LAST-1].quad_base;
    res_d.data[164:149] = side_q[LAST-1].quad_below;
    res_d.user          = {side_q[LAST-1].oor, side_q[LAST-1].quad_valid};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_fire = out_valid_q && m_axis_tready;
  assign push     = en && valid_q[LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      spare_valid_q <= 1'b0;
    end else if (spare_valid_q) begin
      if (out_fire) begin
        spare_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !out_fire) begin
        spare_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (spare_valid_q) begin
      if (out_fire) begin
        out_q <= spare_q;
      end
    end else if (push) begin
      if (out_valid_q && !out_fire) begin
        spare_q <= res_q;
      end else begin
        out_q <= res_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tuser  = out_q.user;

endmodule

### rtl/uvs_checker.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module uvs_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [167:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
    else $error("out-of-range result carries nonzero data");

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("quad valid and out of range both set");

  a_no_quad_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[164:149] == 16'd0)
    else $error("quad below index set without a quad");

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
